// File: hdl/mavg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mavg_pkg
// Shared types and constants for the moving average min/max tracker.
// ----------------------------------------------------------------------------
package mavg_pkg;

    localparam int LEVEL_W    = 12;
    localparam int THR_W      = 12;
    localparam int THR_RESET  = 512;
    localparam int LOW_RESET  = 256;
    localparam int HIGH_RESET = 512;

    typedef enum logic [1:0] {
        KIND_VALUE = 2'd0,
        KIND_MIN   = 2'd1,
        KIND_MAX   = 2'd2
    } report_kind_t;

endpackage

// File: hdl/mavg_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mavg_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// A read and a write of the same entry in one cycle returns the old data.
// ----------------------------------------------------------------------------
module mavg_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 5
) (
    input  logic                                      aclk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/moving_average_minmax_tracker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moving_average_minmax_tracker_top
// Boxcar moving average over the last WINDOW samples with min/max tracking.
//
//   channel   dir   handshake          payload
//   s_        in    s_valid/s_ready    s_sample
//   m_        out   m_valid/m_ready    m_report_kind, m_level, m_last
//   cfg_      in    cfg_wr_en          cfg_wr_data (calibration threshold)
//
// One sample enters per cycle unless the pipeline stalls or the reset sweep
// runs. A sample yields 1 to 3 reports, or none when absorbed; the single
// output register sends one report per cycle unless m_ready holds it. The
// first report passes stage registers b, c, d and the output register.
// The sample ring sits in a RAM read and rewritten at the ring position in
// the cycle of the transfer. Reset clears every ring entry by a sweep with
// s_ready low. A stall on m_ready holds the stages behind a pending report.
// ----------------------------------------------------------------------------
module moving_average_minmax_tracker_top #(
    parameter int WINDOW      = 5,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [SAMPLE_BITS-1:0]           s_sample,
    output logic                             m_valid,
    input  logic                             m_ready,
    output mavg_pkg::report_kind_t           m_report_kind,
    output logic [mavg_pkg::LEVEL_W-1:0]     m_level,
    output logic                             m_last,
    input  logic                             cfg_wr_en,
    input  logic [mavg_pkg::THR_W-1:0]       cfg_wr_data
);
    import mavg_pkg::*;

    localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int LOG_W  = $clog2(WINDOW);
    localparam int TOT_W  = SAMPLE_BITS + LOG_W;
    localparam int SH     = TOT_W + LOG_W;
    localparam int EXT_W  = (SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W;
    localparam longint unsigned RECIP_L = ((64'd1 << SH) + WINDOW - 1) / WINDOW;
    localparam logic [TOT_W:0] RECIP  = RECIP_L[TOT_W:0];

    // clearing sweep
    logic                   clr_busy_reg;
    logic [POS_W-1:0]       clr_pos_reg;

    logic [POS_W-1:0]       pos_reg;
    logic [POS_W-1:0]       pos_next;
    logic                   b_valid_reg;
    logic [SAMPLE_BITS-1:0] b_sample_reg;
    logic [SAMPLE_BITS-1:0] old_sample;
    logic [TOT_W-1:0]       total_reg;
    logic [TOT_W-1:0]       total_next;
    logic                   c_valid_reg;
    logic [TOT_W-1:0]       c_total_reg;
    logic [2*TOT_W:0]       product;
    logic [EXT_W-1:0]       avg_c;
    logic                   d_valid_reg;
    logic [EXT_W-1:0]       d_avg_reg;
    logic                   cal_reg;
    logic [EXT_W-1:0]       low_reg;
    logic [EXT_W-1:0]       high_reg;
    logic [THR_W-1:0]       thr_reg;
    logic                   sent_min_reg;
    logic                   sent_max_reg;
    logic                   m_valid_reg;
    report_kind_t           m_kind_reg;
    logic [LEVEL_W-1:0]     m_level_reg;
    logic                   m_last_reg;

    logic                   absorb;
    logic                   need_min;
    logic                   need_max;
    report_kind_t           cur_kind;
    logic                   out_free;
    logic                   emit;
    logic                   d_done;
    logic                   adv;
    logic                   accept;
    logic                   ram_wr_en;
    logic [POS_W-1:0]       ram_wr_addr;
    logic [SAMPLE_BITS-1:0] ram_wr_data;

    // ring storage
    mavg_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (accept),
        .rd_addr (pos_reg),
        .rd_data (old_sample)
    );

    assign ram_wr_en   = clr_busy_reg || accept;
    assign ram_wr_addr = clr_busy_reg ? clr_pos_reg : pos_reg;
    assign ram_wr_data = clr_busy_reg ? '0 : s_sample;

    assign adv     = !d_valid_reg || d_done;
    assign s_ready = adv && !clr_busy_reg;
    assign accept  = s_valid && s_ready;

    assign pos_next   = (pos_reg == POS_W'(WINDOW - 1)) ? '0 : pos_reg + 1'b1;
    assign total_next = total_reg - TOT_W'(old_sample) + TOT_W'(b_sample_reg);
    assign product    = (2*TOT_W+1)'(c_total_reg) * (2*TOT_W+1)'(RECIP);
    assign avg_c      = EXT_W'(product[SH +: SAMPLE_BITS]);

    assign absorb   = !cal_reg && (d_avg_reg < EXT_W'(thr_reg));
    assign need_min = !cal_reg || (d_avg_reg < low_reg);
    assign need_max = !cal_reg || (d_avg_reg > high_reg);
    assign cur_kind = (need_min && !sent_min_reg) ? KIND_MIN :
                      (need_max && !sent_max_reg) ? KIND_MAX : KIND_VALUE;
    assign out_free = !m_valid_reg || m_ready;
    assign emit     = d_valid_reg && !absorb && out_free;
    assign d_done   = d_valid_reg && (absorb || (out_free && cur_kind == KIND_VALUE));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_pos_reg  <= '0;
            pos_reg      <= '0;
            total_reg    <= '0;
            b_valid_reg  <= 1'b0;
            c_valid_reg  <= 1'b0;
            d_valid_reg  <= 1'b0;
            cal_reg      <= 1'b0;
            low_reg      <= EXT_W'(LOW_RESET);
            high_reg     <= EXT_W'(HIGH_RESET);
            thr_reg      <= THR_W'(THR_RESET);
            sent_min_reg <= 1'b0;
            sent_max_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (clr_busy_reg) begin
                if (clr_pos_reg == POS_W'(WINDOW - 1)) begin
                    clr_busy_reg <= 1'b0;
                end
                clr_pos_reg <= clr_pos_reg + 1'b1;
            end
            if (cfg_wr_en) begin
                thr_reg <= cfg_wr_data;
            end
            if (adv) begin
                b_valid_reg <= accept;
                c_valid_reg <= b_valid_reg;
                d_valid_reg <= c_valid_reg;
                if (accept) begin
                    pos_reg <= pos_next;
                end
                if (b_valid_reg) begin
                    total_reg <= total_next;
                end
            end
            if (d_done) begin
                sent_min_reg <= 1'b0;
                sent_max_reg <= 1'b0;
                if (!absorb) begin
                    cal_reg <= 1'b1;
                    if (need_min) begin
                        low_reg <= d_avg_reg;
                    end
                    if (need_max) begin
                        high_reg <= d_avg_reg;
                    end
                end
            end else if (emit) begin
                if (cur_kind == KIND_MIN) begin
                    sent_min_reg <= 1'b1;
                end
                if (cur_kind == KIND_MAX) begin
                    sent_max_reg <= 1'b1;
                end
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (adv) begin
            b_sample_reg <= s_sample;
            c_total_reg  <= total_next;
            d_avg_reg    <= avg_c;
        end
        if (emit) begin
            m_kind_reg  <= cur_kind;
            m_level_reg <= d_avg_reg[LEVEL_W-1:0];
            m_last_reg  <= (cur_kind == KIND_VALUE);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_report_kind = m_kind_reg;
    assign m_level       = m_level_reg;
    assign m_last        = m_last_reg;

endmodule

// File: hdl/mavg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mavg_checker
// Port-level checks on the result channel of the tracker, bound to the top.
// ----------------------------------------------------------------------------
module mavg_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input mavg_pkg::report_kind_t        m_report_kind,
    input logic [mavg_pkg::LEVEL_W-1:0]  m_level,
    input logic                          m_last
);
    import mavg_pkg::*;

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_last_on_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last == (m_report_kind == KIND_VALUE)))
        else $error("last flag does not match a value report");

    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_report_kind == KIND_VALUE || m_report_kind == KIND_MIN ||
                     m_report_kind == KIND_MAX))
        else $error("undefined report kind");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_report_kind) &&
                                $stable(m_level) && $stable(m_last))
        else $error("stalled result changed");

endmodule

bind moving_average_minmax_tracker_top mavg_checker u_mavg_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_report_kind (m_report_kind),
    .m_level       (m_level),
    .m_last        (m_last)
);
